// ===== hdl/hsvrgb_pkg.sv =====
// Shared types and constants for the HSV to RGB converter.
// Used by every module under hdl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int HUE_W      = 15;
	localparam int SV_W       = 13;
	localparam int CH_W       = 8;

	// clamped saturation / value hold 0..ONE
	localparam int ONE_W      = FRAC_BITS + 1;
	localparam int HUE_SECTOR = 3840;
	localparam int REM_W      = 12;
	localparam int SECT_W     = 4;
	// 3840 * ONE < 2^(FRAC_BITS + 12)
	localparam int W_W        = FRAC_BITS + 12;
	localparam int SR_W       = ONE_W + REM_W;
	localparam int VW_W       = ONE_W + W_W;
	localparam int VP_W       = 2 * ONE_W;

	localparam logic [ONE_W-1:0] ONE  = ONE_W'(1) << FRAC_BITS;
	localparam logic [W_W-1:0]   FULL = W_W'(HUE_SECTOR) << FRAC_BITS;

	// hue / 3840 == (hue >> 8) / 15 ~= ((hue >> 8) * 137) >> 11, exact for 7-bit operands
	localparam int DIV15_MUL   = 137;
	localparam int DIV15_SHIFT = 11;

	// 255 / 15 = 17: the 1/15 of the hue fraction folds into the 255 scale
	localparam int MUL17  = 17;
	localparam int MUL255 = 255;

	// sectors, named by the hue span they cover; anything above falls in magenta-red
	localparam logic [SECT_W-1:0] SEC_RY = SECT_W'(0);
	localparam logic [SECT_W-1:0] SEC_YG = SECT_W'(1);
	localparam logic [SECT_W-1:0] SEC_GC = SECT_W'(2);
	localparam logic [SECT_W-1:0] SEC_CB = SECT_W'(3);
	localparam logic [SECT_W-1:0] SEC_BM = SECT_W'(4);
	localparam logic [SECT_W-1:0] SEC_MAX = SECT_W'(8);

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SV_W-1:0]  saturation;
		logic [SV_W-1:0]  brightness;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [SECT_W-1:0] sector;
		logic [REM_W-1:0]  rem;
		logic [ONE_W-1:0]  s;
		logic [ONE_W-1:0]  v;
	} s1_t;

	typedef struct packed {
		logic [SECT_W-1:0] sector;
		logic [ONE_W-1:0]  v;
		logic [W_W-1:0]    wq;
		logic [W_W-1:0]    wt;
		logic [ONE_W-1:0]  onems;
		logic [CH_W-1:0]   cv;
	} s2_t;

	typedef struct packed {
		logic [SECT_W-1:0] sector;
		logic [CH_W-1:0]   cv;
		logic [VW_W-1:0]   vq;
		logic [VW_W-1:0]   vt;
		logic [VP_W-1:0]   vp;
	} s3_t;

endpackage

`default_nettype wire

// ===== hdl/hsvrgb_sector.sv =====
// Stage 1: clamps saturation and value, splits hue into sector and remainder.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_sector (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hsv_valid,
	output logic                   hsv_ready,
	input  wire hsvrgb_pkg::hsv_t  hsv,
	output logic                   valid_s1,
	input  wire logic              next_ready,
	output hsvrgb_pkg::s1_t        data_s1
);
	import hsvrgb_pkg::*;

	logic [6:0]              hue_hi;
	logic [14:0]             quot_prod;
	logic [SECT_W-1:0]       sector;
	logic [HUE_W-1:0]        base;
	logic [HUE_W-1:0]        rem_full;
	logic [ONE_W-1:0]        s_cl;
	logic [ONE_W-1:0]        v_cl;

	assign hue_hi    = hsv.hue[HUE_W-1:8];
	assign quot_prod = 15'(hue_hi) * 15'(DIV15_MUL);
	assign sector    = quot_prod[DIV15_SHIFT+SECT_W-1:DIV15_SHIFT];
	assign base      = HUE_W'(sector) * HUE_W'(HUE_SECTOR);
	assign rem_full  = hsv.hue - base;

	assign s_cl = (hsv.saturation > SV_W'(ONE)) ? ONE : hsv.saturation[ONE_W-1:0];
	assign v_cl = (hsv.brightness > SV_W'(ONE)) ? ONE : hsv.brightness[ONE_W-1:0];

	assign hsv_ready = !valid_s1 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hsv_ready) begin
			valid_s1 <= hsv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hsv_valid && hsv_ready) begin
			data_s1.sector <= sector;
			data_s1.rem    <= rem_full[REM_W-1:0];
			data_s1.s      <= s_cl;
			data_s1.v      <= v_cl;
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (data_s1.rem < REM_W'(HUE_SECTOR)))
		else $error("hue remainder out of sector range");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (data_s1.sector <= SEC_MAX))
		else $error("hue sector beyond largest input");

endmodule

`default_nettype wire

// ===== hdl/hsvrgb_mix.sv =====
// Stages 2 and 3: forms the q and t weights, then scales p, q, t terms by value.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_mix (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	output logic                  ready_s1,
	input  wire hsvrgb_pkg::s1_t  data_s1,
	output logic                  valid_s3,
	input  wire logic             next_ready,
	output hsvrgb_pkg::s3_t       data_s3
);
	import hsvrgb_pkg::*;

	logic                  valid_s2;
	logic                  ready_s2;
	s2_t                   data_s2;
	logic [SR_W-1:0]       sr_q;
	logic [SR_W-1:0]       sr_t;
	logic [ONE_W+7:0]      v255;
	logic [W_W+1:0]        w_sum;
	logic [W_W+1:0]        s_term;

	// stage 2
	assign sr_q = SR_W'(data_s1.s) * SR_W'(data_s1.rem);
	assign sr_t = SR_W'(data_s1.s) * SR_W'(REM_W'(HUE_SECTOR) - data_s1.rem);
	assign v255 = (ONE_W+8)'(data_s1.v) * (ONE_W+8)'(MUL255);

	assign ready_s1 = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			data_s2.sector <= data_s1.sector;
			data_s2.v      <= data_s1.v;
			data_s2.wq     <= FULL - sr_q[W_W-1:0];
			data_s2.wt     <= FULL - sr_t[W_W-1:0];
			data_s2.onems  <= ONE - data_s1.s;
			data_s2.cv     <= v255[FRAC_BITS+CH_W-1:FRAC_BITS];
		end
	end

	// stage 3
	assign ready_s2 = !valid_s3 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s2) begin
			data_s3.sector <= data_s2.sector;
			data_s3.cv     <= data_s2.cv;
			data_s3.vq     <= VW_W'(data_s2.v) * VW_W'(data_s2.wq);
			data_s3.vt     <= VW_W'(data_s2.v) * VW_W'(data_s2.wt);
			data_s3.vp     <= VP_W'(data_s2.v) * VP_W'(data_s2.onems);
		end
	end

	// q and t weights always add to 2*FULL - s*3840
	assign w_sum  = (W_W+2)'(data_s2.wq) + (W_W+2)'(data_s2.wt);
	assign s_term = (W_W+2)'(ONE - data_s2.onems) * (W_W+2)'(HUE_SECTOR);

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (w_sum + s_term == ((W_W+2)'(FULL) << 1)))
		else $error("q/t weights inconsistent with saturation");

endmodule

`default_nettype wire

// ===== hdl/hsvrgb_route.sv =====
// Stage 4: scales terms to 8-bit channels, routes them by sector, holds the output word.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_route (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s3,
	output logic                  ready_s3,
	input  wire hsvrgb_pkg::s3_t  data_s3,
	output logic                  rgb_valid,
	input  wire logic             rgb_ready,
	output hsvrgb_pkg::rgb_t      rgb
);
	import hsvrgb_pkg::*;

	logic [VW_W+4:0]   q17;
	logic [VW_W+4:0]   t17;
	logic [VP_W+7:0]   p255;
	logic [CH_W-1:0]   cq;
	logic [CH_W-1:0]   ct;
	logic [CH_W-1:0]   cp;
	rgb_t              rgb_d;

	assign q17  = (VW_W+5)'(data_s3.vq) * (VW_W+5)'(MUL17);
	assign t17  = (VW_W+5)'(data_s3.vt) * (VW_W+5)'(MUL17);
	assign p255 = (VP_W+8)'(data_s3.vp) * (VP_W+8)'(MUL255);

	assign cq = q17[2*FRAC_BITS+8+CH_W-1:2*FRAC_BITS+8];
	assign ct = t17[2*FRAC_BITS+8+CH_W-1:2*FRAC_BITS+8];
	assign cp = p255[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];

	always_comb begin
		case (data_s3.sector)
			SEC_RY: rgb_d = '{red: data_s3.cv, green: ct, blue: cp};
			SEC_YG: rgb_d = '{red: cq, green: data_s3.cv, blue: cp};
			SEC_GC: rgb_d = '{red: cp, green: data_s3.cv, blue: ct};
			SEC_CB: rgb_d = '{red: cp, green: cq, blue: data_s3.cv};
			SEC_BM: rgb_d = '{red: ct, green: cp, blue: data_s3.cv};
			default: rgb_d = '{red: data_s3.cv, green: cp, blue: cq};
		endcase
	end

	assign ready_s3 = !rgb_valid || rgb_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_valid <= 1'b0;
		end else if (ready_s3) begin
			rgb_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s3) begin
			rgb <= rgb_d;
		end
	end

	// v is the largest component; p, q, t never exceed it
	a_v_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (cp <= data_s3.cv && cq <= data_s3.cv && ct <= data_s3.cv))
		else $error("p/q/t channel exceeds v channel");

endmodule

`default_nettype wire

// ===== hdl/hsv_to_rgb_converter_top.sv =====
// HSV to RGB converter, top level: four-stage pipeline.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_mix, hsvrgb_route.
//
// Usage:
//   Input channel hsv_valid / hsv_ready / hsv carries one HSV word: hue in
//   1/64 degree (23040 and up maps to the magenta-red sector), saturation and
//   brightness in Q12 with 4096 = 1.0 (larger values clamp to 1.0).
//   Output channel rgb_valid / rgb_ready / rgb carries the 8-bit red, green
//   and blue channels, each floor(component * 255), exact.
//   Throughput: one word per clock while rgb_ready holds high, set by the
//   four registered stages (sector split, q/t weights, value products,
//   channel scale and routing).
//   Reset clears all stage valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls, each stage holds its word and takes a new one
//   only as the stage ahead frees up, so up to four words wait inside and
//   hsv_ready drops only when all stages are full.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hsv_valid,
	output logic                   hsv_ready,
	input  wire hsvrgb_pkg::hsv_t  hsv,
	output logic                   rgb_valid,
	input  wire logic              rgb_ready,
	output hsvrgb_pkg::rgb_t       rgb
);
	import hsvrgb_pkg::*;

	logic  valid_s1;
	logic  ready_s1;
	s1_t   data_s1;
	logic  valid_s3;
	logic  ready_s3;
	s3_t   data_s3;

	hsvrgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hsv        (hsv),
		.valid_s1   (valid_s1),
		.next_ready (ready_s1),
		.data_s1    (data_s1)
	);

	hsvrgb_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.ready_s1   (ready_s1),
		.data_s1    (data_s1),
		.valid_s3   (valid_s3),
		.next_ready (ready_s3),
		.data_s3    (data_s3)
	);

	hsvrgb_route u_route (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s3   (valid_s3),
		.ready_s3   (ready_s3),
		.data_s3    (data_s3),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.rgb        (rgb)
	);

endmodule

`default_nettype wire
